// ===== src/time_entry_digit_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// time entry digit parser assertion macros
// shared property wrappers, sampled on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef TIME_ENTRY_DIGIT_PARSER_UNIT_DEFINES_SVH
`define TIME_ENTRY_DIGIT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define TEDP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tedp assertion failed");

// next-cycle implication
`define TEDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tedp assertion failed");

`endif

// ===== src/tedp_pkg.sv =====
// ----------------------------------------------------------------------------
// tedp_pkg
// types and constants of the time entry digit parser
// ----------------------------------------------------------------------------
`default_nettype none

package tedp_pkg;

  localparam int unsigned DIGITS_PER_ENTRY = 12;
  localparam int unsigned STORE_DEPTH      = DIGITS_PER_ENTRY - 1;
  localparam int unsigned COUNT_W          = 4;
  localparam int unsigned DIGITS_W         = 4 * DIGITS_PER_ENTRY;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_BS   = 8'h08;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [6:0] HOUR_LIMIT  = 7'd24;
  localparam logic [6:0] MIN_LIMIT   = 7'd60;
  localparam logic [6:0] DAY_LIMIT   = 7'd32;
  localparam logic [6:0] MONTH_LIMIT = 7'd13;

  localparam logic [0:0] ACTION_START = 1'b0;

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_ECHO     = 3'd1,
    KIND_ERASED   = 3'd2,
    KIND_REJECTED = 3'd3,
    KIND_ACCEPTED = 3'd4,
    KIND_INVALID  = 3'd5,
    KIND_STARTED  = 3'd6
  } kind_e;

  // command from front to back; KIND_ACCEPTED here means "check the digits"
  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            echo_char;
    logic [DIGITS_W-1:0]   digits;
  } cmd_t;

  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] count;
  } front_stat_t;

  function automatic logic [6:0] pair_value(input logic [3:0] tens, input logic [3:0] ones);
    logic [6:0] t;
    t = {3'b000, tens};
    return (t << 3) + (t << 1) + {3'b000, ones};
  endfunction

endpackage

`default_nettype wire

// ===== src/tedp_if.sv =====
// ----------------------------------------------------------------------------
// tedp_if
// valid/ready channels for character requests and parse results
// ----------------------------------------------------------------------------
`default_nettype none

interface tedp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface tedp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] echo_char;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [4:0] day_of_month;
  logic [3:0] month_number;
  logic [6:0] year_in_century;

  modport source (output valid, output kind, output echo_char, output hours,
                  output minutes, output seconds, output day_of_month,
                  output month_number, output year_in_century, input ready);
  modport sink   (input valid, input kind, input echo_char, input hours,
                  input minutes, input seconds, input day_of_month,
                  input month_number, input year_in_century, output ready);
endinterface

`default_nettype wire

// ===== src/tedp_front.sv =====
// ----------------------------------------------------------------------------
// tedp_front
// accepts requests, tracks entry mode and digits, issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module tedp_front import tedp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        action_i,
  input  logic [7:0]  char_code_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output cmd_t        push_cmd_o,
  output front_stat_t stat_o
);

  logic               active_q, active_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [3:0]         store_q [STORE_DEPTH];
  logic               accept;
  logic               is_digit;
  logic               is_last;
  logic               store_we;

  assign req_ready_o  = push_ready_i;
  assign push_valid_o = req_valid_i;
  assign accept       = req_valid_i && push_ready_i;
  assign is_digit     = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign is_last      = (count_q == COUNT_W'(DIGITS_PER_ENTRY - 1));
  assign stat_o       = '{active: active_q, count: count_q};

  always_comb begin
    active_d             = active_q;
    count_d              = count_q;
    store_we             = 1'b0;
    push_cmd_o.kind      = KIND_IGNORED;
    push_cmd_o.echo_char = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      push_cmd_o.digits[4*i +: 4] = store_q[i];
    end
    push_cmd_o.digits[DIGITS_W-1 -: 4] = char_code_i[3:0];

    if (action_i == ACTION_START) begin
      active_d        = 1'b1;
      count_d         = '0;
      push_cmd_o.kind = KIND_STARTED;
    end else if (!active_q || (count_q >= COUNT_W'(DIGITS_PER_ENTRY))) begin
      push_cmd_o.kind = KIND_IGNORED;
    end else if (is_digit) begin
      if (is_last) begin
        push_cmd_o.kind = KIND_ACCEPTED;
        active_d        = 1'b0;
        count_d         = '0;
      end else begin
        store_we             = 1'b1;
        count_d              = count_q + COUNT_W'(1);
        push_cmd_o.kind      = KIND_ECHO;
        push_cmd_o.echo_char = char_code_i;
      end
    end else if ((char_code_i == CHAR_BS) || (char_code_i == CHAR_DEL)) begin
      if (count_q != '0) begin
        count_d         = count_q - COUNT_W'(1);
        push_cmd_o.kind = KIND_ERASED;
      end
    end else if ((char_code_i == CHAR_CR) || (char_code_i == CHAR_LF)) begin
      push_cmd_o.kind = KIND_IGNORED;
    end else begin
      count_d         = '0;
      push_cmd_o.kind = KIND_REJECTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
    end else if (accept) begin
      active_q <= active_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      store_q[count_q] <= char_code_i[3:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/tedp_queue.sv =====
// ----------------------------------------------------------------------------
// tedp_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tedp_queue import tedp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/tedp_back.sv =====
// ----------------------------------------------------------------------------
// tedp_back
// forms and range-checks the time fields, holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tedp_back import tedp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output kind_e      kind_o,
  output logic [7:0] echo_char_o,
  output logic [4:0] hours_o,
  output logic [5:0] minutes_o,
  output logic [5:0] seconds_o,
  output logic [4:0] day_of_month_o,
  output logic [3:0] month_number_o,
  output logic [6:0] year_in_century_o
);

  logic       valid_q;
  kind_e      kind_q, kind_d;
  logic [7:0] echo_q;
  logic [6:0] hh, mi, ss, dd, mo, yy;
  logic [6:0] hh_q, mi_q, ss_q, dd_q, mo_q, yy_q;
  logic [6:0] hh_d, mi_d, ss_d, dd_d, mo_d, yy_d;
  logic       time_ok;
  logic       load;

  assign pop_ready_o = !valid_q || rsp_ready_i;
  assign load        = pop_valid_i && pop_ready_o;

  assign hh = pair_value(pop_cmd_i.digits[3:0],   pop_cmd_i.digits[7:4]);
  assign mi = pair_value(pop_cmd_i.digits[11:8],  pop_cmd_i.digits[15:12]);
  assign ss = pair_value(pop_cmd_i.digits[19:16], pop_cmd_i.digits[23:20]);
  assign dd = pair_value(pop_cmd_i.digits[27:24], pop_cmd_i.digits[31:28]);
  assign mo = pair_value(pop_cmd_i.digits[35:32], pop_cmd_i.digits[39:36]);
  assign yy = pair_value(pop_cmd_i.digits[43:40], pop_cmd_i.digits[47:44]);

  assign time_ok = (hh < HOUR_LIMIT) && (mi < MIN_LIMIT) && (ss < MIN_LIMIT) &&
                   (dd != '0) && (dd < DAY_LIMIT) && (mo != '0) && (mo < MONTH_LIMIT);

  always_comb begin
    kind_d = pop_cmd_i.kind;
    hh_d   = '0;
    mi_d   = '0;
    ss_d   = '0;
    dd_d   = '0;
    mo_d   = '0;
    yy_d   = '0;
    if (pop_cmd_i.kind == KIND_ACCEPTED) begin
      if (time_ok) begin
        hh_d = hh;
        mi_d = mi;
        ss_d = ss;
        dd_d = dd;
        mo_d = mo;
        yy_d = yy;
      end else begin
        kind_d = KIND_INVALID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      echo_q <= pop_cmd_i.echo_char;
      hh_q   <= hh_d;
      mi_q   <= mi_d;
      ss_q   <= ss_d;
      dd_q   <= dd_d;
      mo_q   <= mo_d;
      yy_q   <= yy_d;
    end
  end

  assign rsp_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign echo_char_o       = echo_q;
  assign hours_o           = hh_q[4:0];
  assign minutes_o         = mi_q[5:0];
  assign seconds_o         = ss_q[5:0];
  assign day_of_month_o    = dd_q[4:0];
  assign month_number_o    = mo_q[3:0];
  assign year_in_century_o = yy_q;

endmodule

`default_nettype wire

// ===== src/time_entry_digit_parser_unit.sv =====
// ----------------------------------------------------------------------------
// time_entry_digit_parser_unit
// Takes one request per cycle while the command queue has room: a start
// request arms entry mode, a character request carries one received ASCII
// code. Each request gives exactly one result, registered in a queue entry
// and then in the back stage's result register. The front stage
// updates entry mode, the digit count and the digit store as each request
// is accepted; a two-entry command queue and the back stage's result
// register keep the two sides independent. On the twelfth digit the back
// stage forms HHMMSSDDMMYY and range-checks it in its single register stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_entry_digit_parser_unit_defines.svh"

module time_entry_digit_parser_unit import tedp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tedp_in_if.sink    in_i,
  tedp_out_if.source out_o
);

  logic        push_valid, push_ready;
  cmd_t        push_cmd;
  logic        pop_valid, pop_ready;
  cmd_t        pop_cmd;
  front_stat_t front_stat;
  kind_e       kind;

  tedp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_i.valid),
    .req_ready_o  (in_i.ready),
    .action_i     (in_i.action),
    .char_code_i  (in_i.char_code),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .stat_o       (front_stat)
  );

  tedp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tedp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_cmd_i         (pop_cmd),
    .rsp_valid_o       (out_o.valid),
    .rsp_ready_i       (out_o.ready),
    .kind_o            (kind),
    .echo_char_o       (out_o.echo_char),
    .hours_o           (out_o.hours),
    .minutes_o         (out_o.minutes),
    .seconds_o         (out_o.seconds),
    .day_of_month_o    (out_o.day_of_month),
    .month_number_o    (out_o.month_number),
    .year_in_century_o (out_o.year_in_century)
  );

  assign out_o.kind = kind;

  // digit count stays within one entry
  `TEDP_ASSERT_SAME(a_count_range, 1'b1,
                    front_stat.count < COUNT_W'(DIGITS_PER_ENTRY))

  // start request arms entry mode with an empty count
  `TEDP_ASSERT_NEXT(a_start_arms, in_i.valid && in_i.ready && (in_i.action == ACTION_START),
                    front_stat.active && (front_stat.count == '0))

  // accepted time is in range
  `TEDP_ASSERT_SAME(a_time_range, out_o.valid && (kind == KIND_ACCEPTED),
                    (out_o.hours < 5'd24) && (out_o.minutes < 6'd60) &&
                    (out_o.seconds < 6'd60) && (out_o.day_of_month != '0) &&
                    (out_o.month_number != '0) && (out_o.month_number < 4'd13))

  // time fields are zero unless the time was accepted
  `TEDP_ASSERT_SAME(a_fields_zero, out_o.valid && (kind != KIND_ACCEPTED),
                    (out_o.hours == '0) && (out_o.minutes == '0) &&
                    (out_o.seconds == '0) && (out_o.day_of_month == '0) &&
                    (out_o.month_number == '0) && (out_o.year_in_century == '0))

endmodule

`default_nettype wire

// ===== dv/tedp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tedp_checker
// Watches the request and result channels of the time entry digit parser.
// Keeps its own copy of entry mode, digit count and digit store, predicts
// the result of every accepted request and compares each accepted result,
// field by field, with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module tedp_checker import tedp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tedp_in_if   req_i,
  tedp_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   taken_o
);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] echo;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } parse_res_t;

  logic               armed;
  logic [COUNT_W-1:0] n_digits;
  logic [3:0]         digit_mem [DIGITS_PER_ENTRY];
  parse_res_t         results_due [$];

  function automatic parse_res_t parse_request(input logic act, input logic [7:0] ch);
    parse_res_t r;
    int hh, mi, ss, dd, mo, yy;
    r = '0;
    r.kind = KIND_IGNORED;
    if (act == ACTION_START) begin
      armed    = 1'b1;
      n_digits = '0;
      r.kind   = KIND_STARTED;
    end else if (!armed || n_digits >= DIGITS_PER_ENTRY) begin
      r.kind = KIND_IGNORED;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      digit_mem[n_digits] = 4'(ch - CHAR_ZERO);
      n_digits = n_digits + 1'b1;
      if (n_digits < DIGITS_PER_ENTRY) begin
        r.kind = KIND_ECHO;
        r.echo = ch;
      end else begin
        hh = digit_mem[0] * 10 + digit_mem[1];
        mi = digit_mem[2] * 10 + digit_mem[3];
        ss = digit_mem[4] * 10 + digit_mem[5];
        dd = digit_mem[6] * 10 + digit_mem[7];
        mo = digit_mem[8] * 10 + digit_mem[9];
        yy = digit_mem[10] * 10 + digit_mem[11];
        if (hh < HOUR_LIMIT && mi < MIN_LIMIT && ss < MIN_LIMIT &&
            dd > 0 && dd < DAY_LIMIT && mo > 0 && mo < MONTH_LIMIT) begin
          r.kind    = KIND_ACCEPTED;
          r.hours   = 5'(hh);
          r.minutes = 6'(mi);
          r.seconds = 6'(ss);
          r.day     = 5'(dd);
          r.month   = 4'(mo);
          r.year    = 7'(yy);
        end else begin
          r.kind = KIND_INVALID;
        end
        armed    = 1'b0;
        n_digits = '0;
      end
    end else if (ch == CHAR_BS || ch == CHAR_DEL) begin
      if (n_digits != 0) begin
        n_digits = n_digits - 1'b1;
        r.kind   = KIND_ERASED;
      end
    end else if (ch == CHAR_CR || ch == CHAR_LF) begin
      r.kind = KIND_IGNORED;
    end else begin
      n_digits = '0;
      r.kind   = KIND_REJECTED;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_res_t seen_res;
    parse_res_t due_res;
    if (!rst_ni) begin
      armed    = 1'b0;
      n_digits = '0;
      results_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      taken_o      = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen_res.kind    = kind_e'(res_i.kind);
        seen_res.echo    = res_i.echo_char;
        seen_res.hours   = res_i.hours;
        seen_res.minutes = res_i.minutes;
        seen_res.seconds = res_i.seconds;
        seen_res.day     = res_i.day_of_month;
        seen_res.month   = res_i.month_number;
        seen_res.year    = res_i.year_in_century;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d", $time, res_i.kind);
          fail_count_o++;
        end else begin
          due_res = results_due.pop_front();
          if (seen_res !== due_res) begin
            $display("%0t: expected kind %0d echo %02h %0d:%0d:%0d %0d/%0d/%0d",
                     $time, due_res.kind, due_res.echo, due_res.hours, due_res.minutes,
                     due_res.seconds, due_res.day, due_res.month, due_res.year,
                     ", got kind %0d echo %02h %0d:%0d:%0d %0d/%0d/%0d",
                     seen_res.kind, seen_res.echo, seen_res.hours, seen_res.minutes,
                     seen_res.seconds, seen_res.day, seen_res.month, seen_res.year);
            fail_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        due_res = parse_request(req_i.action, req_i.char_code);
        results_due.push_back(due_res);
        taken_o++;
      end
      pending_o = results_due.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the time entry digit parser. Sends a short directed run of
// start and character requests, then random time entries of twelve digits
// with line-ending and erase noise mixed in, and random garbage requests.
// The sender works in bursts, the result side stalls in changing patterns,
// and a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import tedp_pkg::*;

  localparam logic ACTION_CHAR = 1'b1;
  localparam int   WANT_TAKEN  = 1650;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       req_valid  = 1'b0;
  logic       req_action = ACTION_START;
  logic [7:0] req_char   = 8'h00;
  logic       recv_ready = 1'b0;
  int         burst_left = 0;
  int         fail_count;
  int         pending;
  int         taken;

  tedp_in_if  req_if ();
  tedp_out_if res_if ();

  assign req_if.valid     = req_valid;
  assign req_if.action    = req_action;
  assign req_if.char_code = req_char;
  assign res_if.ready     = recv_ready;

  time_entry_digit_parser_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  tedp_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .taken_o      (taken)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stall patterns, switched at random among four styles
  always @(posedge clk_i) begin
    int unsigned cyc;
    int unsigned style;
    cyc = cyc + 1;
    if (cyc % 256 == 0) style = $urandom_range(0, 3);
    case (style)
      0: recv_ready <= 1'b1;
      1: recv_ready <= ($urandom_range(0, 3) != 0);
      2: recv_ready <= ($urandom_range(0, 3) == 0);
      default: recv_ready <= (cyc % 8 < 5);
    endcase
  end

  task automatic send_req(input logic act, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_valid  <= 1'b1;
    req_action <= act;
    req_char   <= ch;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one entry of twelve digits, mostly in range, with noise that keeps it whole
  task automatic send_entry();
    logic [3:0] dig [DIGITS_PER_ENTRY];
    int hh, mi, ss, dd, mo, yy, style, k;
    hh = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    ss = $urandom_range(0, 59);
    dd = $urandom_range(1, 31);
    mo = $urandom_range(1, 12);
    yy = $urandom_range(0, 99);
    style = $urandom_range(0, 9);
    if (style >= 6 && style < 8) begin
      case ($urandom_range(0, 4))
        0: hh = $urandom_range(24, 99);
        1: mi = $urandom_range(60, 99);
        2: ss = $urandom_range(60, 99);
        3: dd = $urandom_range(0, 1) ? $urandom_range(32, 99) : 0;
        default: mo = $urandom_range(0, 1) ? $urandom_range(13, 99) : 0;
      endcase
    end
    dig[0]  = 4'(hh / 10); dig[1]  = 4'(hh % 10);
    dig[2]  = 4'(mi / 10); dig[3]  = 4'(mi % 10);
    dig[4]  = 4'(ss / 10); dig[5]  = 4'(ss % 10);
    dig[6]  = 4'(dd / 10); dig[7]  = 4'(dd % 10);
    dig[8]  = 4'(mo / 10); dig[9]  = 4'(mo % 10);
    dig[10] = 4'(yy / 10); dig[11] = 4'(yy % 10);
    if (style >= 8) begin
      for (k = 0; k < DIGITS_PER_ENTRY; k++) dig[k] = 4'($urandom_range(0, 9));
    end
    send_req(ACTION_START, 8'($urandom));
    for (k = 0; k < DIGITS_PER_ENTRY; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_req(ACTION_CHAR, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      if (k > 0 && $urandom_range(0, 15) == 0) begin
        send_req(ACTION_CHAR, $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
        send_req(ACTION_CHAR, CHAR_ZERO + 8'(dig[k-1]));
      end
      send_req(ACTION_CHAR, CHAR_ZERO + 8'(dig[k]));
    end
  endtask

  task automatic send_noise(input int n);
    logic [7:0] ch;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2: ch = CHAR_ZERO + 8'($urandom_range(0, 9));
        3: ch = $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL;
        4: ch = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
        default: ch = 8'($urandom);
      endcase
      send_req(($urandom_range(0, 7) == 0) ? ACTION_START : ACTION_CHAR, ch);
    end
  endtask

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [7:0] full_entry [DIGITS_PER_ENTRY];
    int k;
    full_entry = '{"2", "3", "5", "9", "5", "9", "3", "1", "1", "2", "9", "9"};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle chars, empty erase, line endings, erase, reject, re-arm
    send_req(ACTION_CHAR, "5");
    send_req(ACTION_START, 8'h00);
    send_req(ACTION_CHAR, CHAR_BS);
    send_req(ACTION_CHAR, CHAR_CR);
    send_req(ACTION_CHAR, CHAR_LF);
    send_req(ACTION_CHAR, "0");
    send_req(ACTION_CHAR, CHAR_DEL);
    send_req(ACTION_CHAR, "7");
    send_req(ACTION_CHAR, 8'h00);
    send_req(ACTION_CHAR, "3");
    send_req(ACTION_START, 8'hFF);
    for (k = 0; k < DIGITS_PER_ENTRY; k++) send_req(ACTION_CHAR, full_entry[k]);
    send_req(ACTION_CHAR, 8'hFF);
    drain();

    while (taken < WANT_TAKEN) begin
      if ($urandom_range(0, 9) < 7) send_entry();
      else send_noise($urandom_range(1, 12));
      if ($urandom_range(0, 40) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (pending != 0) $display("tb: %0d parse results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
